// ===== rtl/dhcpopt_pkg.sv =====
// ----------------------------------------------------------------------------
// DHCP option parser package
// Shared constants, phase encodings, record kinds and the record type that
// the options-area parser uses.
// ----------------------------------------------------------------------------
`default_nettype none

package dhcpopt_pkg;

   // Size of the options area and of the hostname buffer, in bytes.
   localparam int OptionsBytes  = 312;
   localparam int HostnameBytes = 64;

   // Width of the byte position counter; it covers the whole options area.
   localparam int PosWidth = 9;

   // Depth of the record queue in front of the response channel.
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   // Option codes of interest.
   localparam logic [7:0] OptPad      = 8'd0;
   localparam logic [7:0] OptMask     = 8'd1;
   localparam logic [7:0] OptRouter   = 8'd3;
   localparam logic [7:0] OptDns      = 8'd6;
   localparam logic [7:0] OptHostname = 8'd12;
   localparam logic [7:0] OptReqIp    = 8'd50;
   localparam logic [7:0] OptLease    = 8'd51;
   localparam logic [7:0] OptMsgType  = 8'd53;
   localparam logic [7:0] OptServerId = 8'd54;
   localparam logic [7:0] OptRelay    = 8'd82;
   localparam logic [7:0] OptEnd      = 8'd255;

   // Relay agent sub-option codes.
   localparam logic [7:0] SubCircuitId = 8'd1;
   localparam logic [7:0] SubRemoteId  = 8'd2;

   // Main walk phase.
   typedef enum logic [1:0] {
      PH_TYPE,
      PH_LEN,
      PH_DATA
   } phase_type;

   // Relay option sub-walk phase.
   typedef enum logic [1:0] {
      SP_TYPE,
      SP_LEN,
      SP_DATA,
      SP_STOP
   } sub_phase_type;

   // Record kinds on the response channel.
   typedef enum logic [3:0] {
      K_MSG     = 4'd0,
      K_REQIP   = 4'd1,
      K_SRVID   = 4'd2,
      K_LEASE   = 4'd3,
      K_MASK    = 4'd4,
      K_ROUTER  = 4'd5,
      K_DNS1    = 4'd6,
      K_DNS2    = 4'd7,
      K_HOST    = 4'd8,
      K_CIRC    = 4'd9,
      K_REMOTE  = 4'd10,
      K_DONE    = 4'd11
   } kind_type;

   // One result record.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] value;
      logic        last;
   } record_type;

endpackage

`default_nettype wire

// ===== rtl/dhcp_option_tlv_parser.sv =====
// ----------------------------------------------------------------------------
// DHCP options-area TLV parser
// Walks the options area byte by byte and emits records for known options,
// relay sub-options and a closing done record.
// ----------------------------------------------------------------------------
// The parser takes one options byte per request and can accept a new request
// in every cycle. Each request is decoded in the cycle in which it is accepted
// and its records (none, one, or two when the byte that fills the area also
// completes a value) are written into a four-entry record queue that drives
// the response channel, one record per cycle while rsp_ready is high. A
// request with packet_start set restarts the walk before its byte is taken;
// bytes that arrive after the walk has stopped, or before the first start,
// produce no records. The request side is held off only while the queue has
// fewer than two free entries, so with a response side that never stalls the
// throughput is one byte per cycle.
`default_nettype none

module dhcp_option_tlv_parser
   import dhcpopt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_option_byte,
   input  wire logic        req_packet_start,
   // Response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_record_kind,
   output logic [31:0]      rsp_record_value,
   output logic             rsp_record_last
);

   // Parser state registers
   logic [PosWidth-1:0] pos_ff,     pos_in;
   phase_type           phase_ff,   phase_in;
   logic [7:0]          type_ff,    type_in;
   logic [7:0]          len_ff,     len_in;
   logic [7:0]          left_ff,    left_in;
   logic [31:0]         acc_ff,     acc_in;
   sub_phase_type       sphase_ff,  sphase_in;
   logic [7:0]          stype_ff,   stype_in;
   logic [7:0]          sleft_ff,   sleft_in;
   logic                stopped_ff, stopped_in;

   // State as seen by the current request, after an optional restart
   logic [PosWidth-1:0] pos_e;
   phase_type           phase_e;
   logic [7:0]          type_e;
   logic [7:0]          len_e;
   logic [7:0]          left_e;
   logic [31:0]         acc_e;
   sub_phase_type       sphase_e;
   logic [7:0]          stype_e;
   logic [7:0]          sleft_e;
   logic                stopped_e;

   logic [7:0]          b;
   logic [7:0]          idx;
   logic [PosWidth:0]   end_sum;
   logic                rec0_valid;
   record_type          rec0;
   logic                rec1_valid;
   record_type          done_rec;

   // Record queue
   record_type             queue_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]     count_ff,  count_in;
   logic [1:0]             push_cnt;
   logic                   req_fire;
   logic                   rsp_fire;
   record_type             slot0;
   record_type             slot1;
   record_type             head;

   assign b        = req_option_byte;
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   assign done_rec.kind  = K_DONE;
   assign done_rec.value = 32'd0;
   assign done_rec.last  = 1'b1;

   // A start request clears the walk before its byte is decoded.
   always_comb begin
      if (req_packet_start) begin
         pos_e     = '0;
         phase_e   = PH_TYPE;
         type_e    = 8'd0;
         len_e     = 8'd0;
         left_e    = 8'd0;
         acc_e     = 32'd0;
         sphase_e  = SP_TYPE;
         stype_e   = 8'd0;
         sleft_e   = 8'd0;
         stopped_e = 1'b0;
      end else begin
         pos_e     = pos_ff;
         phase_e   = phase_ff;
         type_e    = type_ff;
         len_e     = len_ff;
         left_e    = left_ff;
         acc_e     = acc_ff;
         sphase_e  = sphase_ff;
         stype_e   = stype_ff;
         sleft_e   = sleft_ff;
         stopped_e = stopped_ff;
      end
   end

   // Decode one options byte: next parser state and up to two records.
   always_comb begin
      pos_in     = pos_e;
      phase_in   = phase_e;
      type_in    = type_e;
      len_in     = len_e;
      left_in    = left_e;
      acc_in     = acc_e;
      sphase_in  = sphase_e;
      stype_in   = stype_e;
      sleft_in   = sleft_e;
      stopped_in = stopped_e;
      rec0_valid = 1'b0;
      rec0       = done_rec;
      rec1_valid = 1'b0;
      idx        = len_e - left_e;
      end_sum    = {1'b0, pos_e + PosWidth'(1)} + {{(PosWidth-7){1'b0}}, b};

      if (!stopped_e) begin
         pos_in = pos_e + PosWidth'(1);
         case (phase_e)
            PH_TYPE: begin
               if (b == OptEnd) begin
                  stopped_in = 1'b1;
                  rec0_valid = 1'b1;
               end else if (b != OptPad) begin
                  type_in  = b;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               len_in = b;
               if (end_sum > (PosWidth+1)'(OptionsBytes)) begin
                  // The option would run past the area.
                  stopped_in = 1'b1;
                  rec0_valid = 1'b1;
               end else begin
                  left_in   = b;
                  acc_in    = 32'd0;
                  sphase_in = SP_TYPE;
                  stype_in  = 8'd0;
                  sleft_in  = 8'd0;
                  phase_in  = (b == 8'd0) ? PH_TYPE : PH_DATA;
               end
            end
            default: begin
               left_in    = left_e - 8'd1;
               acc_in     = {acc_e[23:0], b};
               rec0.last  = 1'b0;
               rec0.value = {acc_e[23:0], b};
               case (type_e)
                  OptMsgType: begin
                     rec0_valid = (idx == 8'd0);
                     rec0.kind  = K_MSG;
                     rec0.value = {24'd0, b};
                  end
                  OptReqIp: begin
                     rec0_valid = (idx == 8'd3);
                     rec0.kind  = K_REQIP;
                  end
                  OptServerId: begin
                     rec0_valid = (idx == 8'd3);
                     rec0.kind  = K_SRVID;
                  end
                  OptLease: begin
                     rec0_valid = (idx == 8'd3);
                     rec0.kind  = K_LEASE;
                  end
                  OptMask: begin
                     rec0_valid = (idx == 8'd3);
                     rec0.kind  = K_MASK;
                  end
                  OptRouter: begin
                     rec0_valid = (idx == 8'd3);
                     rec0.kind  = K_ROUTER;
                  end
                  OptDns: begin
                     rec0_valid = (idx == 8'd3) || (idx == 8'd7);
                     rec0.kind  = (idx == 8'd3) ? K_DNS1 : K_DNS2;
                  end
                  OptHostname: begin
                     // Only names shorter than the hostname buffer are passed on.
                     rec0_valid = ({1'b0, len_e} < 9'(HostnameBytes));
                     rec0.kind  = K_HOST;
                     rec0.value = {24'd0, b};
                     rec0.last  = (left_in == 8'd0);
                  end
                  OptRelay: begin
                     // Relay agent information: walk its sub-options.
                     case (sphase_e)
                        SP_TYPE: begin
                           stype_in  = b;
                           sphase_in = SP_LEN;
                        end
                        SP_LEN: begin
                           if (b > left_in) begin
                              sphase_in = SP_STOP;
                           end else begin
                              sleft_in  = b;
                              sphase_in = (b == 8'd0) ? SP_TYPE : SP_DATA;
                           end
                        end
                        SP_DATA: begin
                           sleft_in   = sleft_e - 8'd1;
                           rec0_valid = (stype_e == SubCircuitId) ||
                                        (stype_e == SubRemoteId);
                           rec0.kind  = (stype_e == SubCircuitId) ? K_CIRC : K_REMOTE;
                           rec0.value = {24'd0, b};
                           rec0.last  = (sleft_in == 8'd0);
                           if (sleft_in == 8'd0) begin
                              sphase_in = SP_TYPE;
                           end
                        end
                        default: begin
                           sphase_in = SP_STOP;
                        end
                     endcase
                  end
                  default: begin
                     rec0_valid = 1'b0;
                  end
               endcase
               if (left_in == 8'd0) begin
                  phase_in = PH_TYPE;
               end
            end
         endcase

         // The byte that fills the area closes the packet.
         if (!stopped_in && (pos_in >= PosWidth'(OptionsBytes))) begin
            stopped_in = 1'b1;
            rec1_valid = 1'b1;
         end
      end
   end

   // Parser state update on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         phase_ff   <= PH_TYPE;
         type_ff    <= 8'd0;
         len_ff     <= 8'd0;
         left_ff    <= 8'd0;
         acc_ff     <= 32'd0;
         sphase_ff  <= SP_TYPE;
         stype_ff   <= 8'd0;
         sleft_ff   <= 8'd0;
         stopped_ff <= 1'b1;
      end else if (req_fire) begin
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         type_ff    <= type_in;
         len_ff     <= len_in;
         left_ff    <= left_in;
         acc_ff     <= acc_in;
         sphase_ff  <= sphase_in;
         stype_ff   <= stype_in;
         sleft_ff   <= sleft_in;
         stopped_ff <= stopped_in;
      end
   end

   // Pack the records of this request into consecutive queue slots.
   always_comb begin
      slot0    = rec0_valid ? rec0 : done_rec;
      slot1    = done_rec;
      push_cnt = req_fire ? ({1'b0, rec0_valid} + {1'b0, rec1_valid}) : 2'd0;
   end

   // Queue pointer and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrW'(push_cnt);
      rd_ptr_in = rsp_fire ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QueuePtrW+1)'(push_cnt) - (QueuePtrW+1)'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; payload needs no reset.
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + QueuePtrW'(1)] <= slot1;
      end
   end

   // Response side and request flow control.
   assign head             = queue_ff[rd_ptr_ff];
   assign rsp_valid        = (count_ff != '0);
   assign rsp_record_kind  = head.kind;
   assign rsp_record_value = head.value;
   assign rsp_record_last  = head.last;
   assign req_ready        = (count_ff <= (QueuePtrW+1)'(QueueDepth - 2));

   // The queue never holds more records than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QueuePtrW+1)'(QueueDepth))
      else $error("record queue overflow");

   // A stopped walk produces nothing until a new packet starts.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && stopped_ff && !req_packet_start) |-> (push_cnt == 2'd0))
      else $error("records produced while the walk is stopped");

   // Reaching the area end always stops the walk.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && rec1_valid) |=> stopped_ff)
      else $error("walk did not stop at the area end");

   // The byte position never runs past the options area.
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosWidth'(OptionsBytes))
      else $error("byte position beyond the options area");

endmodule

`default_nettype wire
